### rtl/vhim_pkg.sv
// Shared constants and codes for the V0 hypothesis invariant mass block.
package vhim_pkg;

   localparam int MOMENTUM_WIDTH_DEFAULT = 31;
   localparam int ROOT_WIDTH             = 31;
   localparam int MASS_WIDTH             = 20;

   // particle codes (PDG)
   localparam int E_MINUS  = 11;
   localparam int PI_PLUS  = 211;
   localparam int NEG_PION = -211;
   localparam int PROTON   = 2212;

   // hypothesis codes
   localparam logic [2:0] HYP_NONE    = 3'd0;
   localparam logic [2:0] PHOTON      = 3'd1;
   localparam logic [2:0] K_SHORT     = 3'd2;
   localparam logic [2:0] LAMBDA      = 3'd3;
   localparam logic [2:0] ANTI_LAMBDA = 3'd4;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FAILURE  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_ELECTRON_MASS = 2'd0;
   localparam logic [1:0] REG_PION_MASS     = 2'd1;
   localparam logic [1:0] REG_PROTON_MASS   = 2'd2;

   localparam logic [MASS_WIDTH-1:0] ELECTRON_MASS_RESET = 20'd511;
   localparam logic [MASS_WIDTH-1:0] PION_MASS_RESET     = 20'd139570;
   localparam logic [MASS_WIDTH-1:0] PROTON_MASS_RESET   = 20'd938272;

endpackage

### rtl/vhim_isqrt.sv
// Pipelined floored integer square root, one root bit per stage.
module vhim_isqrt
   import vhim_pkg::*;
#(
   parameter int ROOT_WIDTH = vhim_pkg::ROOT_WIDTH
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [2*ROOT_WIDTH-1:0] radicand,
   output logic [ROOT_WIDTH-1:0]   root
);

   localparam int RadWidth = 2 * ROOT_WIDTH;

   logic [RadWidth-1:0]   rem_ff  [ROOT_WIDTH-1];
   logic [ROOT_WIDTH-1:0] root_ff [ROOT_WIDTH];

   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      localparam int Bit = ROOT_WIDTH - 1 - k;
      logic [RadWidth-1:0]   rem_cur;
      logic [RadWidth-1:0]   trial;
      logic [ROOT_WIDTH-1:0] root_cur;
      logic                  take;

      if (k == 0) begin : g_first
         assign rem_cur  = radicand;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      // (q + 2^b)^2 - q^2, q holding only bits above b
      assign trial = (RadWidth'(root_cur) << (Bit + 1)) | (RadWidth'(1) << (2 * Bit));
      assign take  = rem_cur >= trial;

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[k] <= take ? (root_cur | (ROOT_WIDTH'(1) << Bit)) : root_cur;
         end
      end

      if (k < ROOT_WIDTH - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= take ? (rem_cur - trial) : rem_cur;
            end
         end
      end
   end

   assign root = root_ff[ROOT_WIDTH-1];

endmodule

### rtl/v0_hypothesis_invariant_mass.sv
// Top level: V0 hypothesis selection and pipelined two-body invariant mass.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | two momenta, two particle codes
//  rsp     | out       | rsp_valid/rsp_ready  | invariant_mass, hypothesis, status
//  csr     | in        | csr_write_enable     | csr_index, csr_write_data
//
// One pair per cycle while no result waits untaken; the path runs through two 31-stage square root
// pipelines (track energies, then the mass) plus seven arithmetic stages.
// Reset (synchronous) empties the pipeline and restores the default masses.
// The whole pipeline holds while a result waits untaken; req_ready follows
// that hold, so nothing is dropped or repeated.
module v0_hypothesis_invariant_mass
   import vhim_pkg::*;
#(
   parameter int MOMENTUM_WIDTH = MOMENTUM_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [29:0] req_first_px,
   input  logic signed [29:0] req_first_py,
   input  logic signed [29:0] req_first_pz,
   input  logic signed [29:0] req_second_px,
   input  logic signed [29:0] req_second_py,
   input  logic signed [29:0] req_second_pz,
   input  logic signed [24:0] req_first_code,
   input  logic signed [24:0] req_second_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_invariant_mass,
   output logic [2:0]         rsp_hypothesis,
   output logic [1:0]         rsp_status,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [19:0]        csr_write_data
);

   localparam logic signed [31:0] MomLimit =
      32'((longint'(1) <<< (MOMENTUM_WIDTH - 1)) - 1);
   localparam int Rw = ROOT_WIDTH;

   // configuration
   logic [MASS_WIDTH-1:0] electron_mass_ff, pion_mass_ff, proton_mass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         electron_mass_ff <= ELECTRON_MASS_RESET;
         pion_mass_ff     <= PION_MASS_RESET;
         proton_mass_ff   <= PROTON_MASS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ELECTRON_MASS: electron_mass_ff <= csr_write_data;
            REG_PION_MASS:     pion_mass_ff     <= csr_write_data;
            REG_PROTON_MASS:   proton_mass_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   function automatic logic signed [29:0] clamp_mom(logic signed [29:0] v);
      logic signed [31:0] w;
      w = {{2{v[29]}}, v};
      if (w > MomLimit) w = MomLimit;
      else if (w < -MomLimit) w = -MomLimit;
      return w[29:0];
   endfunction

   function automatic logic [24:0] code_abs(logic signed [24:0] c);
      return c[24] ? 25'(-c) : 25'(c);
   endfunction

   function automatic logic [29:0] mag30(logic signed [29:0] v);
      return v[29] ? 30'(-v) : 30'(v);
   endfunction

   function automatic logic [30:0] mag31(logic signed [30:0] v);
      return v[30] ? 31'(-v) : 31'(v);
   endfunction

   // ---- stage 1: clamp, decode, component sums
   logic signed [29:0] p1_in [3], p2_in [3];
   logic signed [30:0] ps_in [3];
   logic [24:0]        abs1, abs2;
   logic [2:0]         hyp1_in;
   logic [MASS_WIDTH-1:0] m1_in, m2_in;

   always_comb begin
      p1_in[0] = clamp_mom(req_first_px);
      p1_in[1] = clamp_mom(req_first_py);
      p1_in[2] = clamp_mom(req_first_pz);
      p2_in[0] = clamp_mom(req_second_px);
      p2_in[1] = clamp_mom(req_second_py);
      p2_in[2] = clamp_mom(req_second_pz);
      for (int i = 0; i < 3; i++) begin
         ps_in[i] = {p1_in[i][29], p1_in[i]} + {p2_in[i][29], p2_in[i]};
      end
      abs1    = code_abs(req_first_code);
      abs2    = code_abs(req_second_code);
      hyp1_in = HYP_NONE;
      m1_in   = '0;
      m2_in   = '0;
      if (abs1 == 25'(E_MINUS) && abs2 == 25'(E_MINUS)) begin
         hyp1_in = PHOTON;
         m1_in   = electron_mass_ff;
         m2_in   = electron_mass_ff;
      end else if (abs1 == 25'(PI_PLUS) && abs2 == 25'(PI_PLUS)) begin
         hyp1_in = K_SHORT;
         m1_in   = pion_mass_ff;
         m2_in   = pion_mass_ff;
      end else if (abs1 == 25'(PROTON) && abs2 == 25'(-NEG_PION)) begin
         hyp1_in = (req_first_code == 25'(PROTON)) ? LAMBDA : ANTI_LAMBDA;
         m1_in   = proton_mass_ff;
         m2_in   = pion_mass_ff;
      end else if (abs1 == 25'(-NEG_PION) && abs2 == 25'(PROTON)) begin
         hyp1_in = (req_second_code == 25'(PROTON)) ? LAMBDA : ANTI_LAMBDA;
         m1_in   = pion_mass_ff;
         m2_in   = proton_mass_ff;
      end
   end

   logic signed [29:0]    p1_ff [3], p2_ff [3];
   logic signed [30:0]    ps_ff [3];
   logic [MASS_WIDTH-1:0] m1_ff, m2_ff;
   logic [2:0]            hyp1_ff;
   logic                  v1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         ps_ff   <= ps_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         hyp1_ff <= hyp1_in;
      end
   end

   // ---- stage 2: squares
   logic [59:0] sq1_ff [3], sq2_ff [3];
   logic [61:0] sqs_ff [3];
   logic [39:0] msq1_ff, msq2_ff;
   logic [2:0]  hyp2_ff;
   logic        v2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            sq1_ff[i] <= mag30(p1_ff[i]) * mag30(p1_ff[i]);
            sq2_ff[i] <= mag30(p2_ff[i]) * mag30(p2_ff[i]);
            sqs_ff[i] <= mag31(ps_ff[i]) * mag31(ps_ff[i]);
         end
         msq1_ff <= m1_ff * m1_ff;
         msq2_ff <= m2_ff * m2_ff;
         hyp2_ff <= hyp1_ff;
      end
   end

   // ---- stage 3: radicands and total momentum squared
   logic [61:0] rad1_ff, rad2_ff, pt3_ff;
   logic [2:0]  hyp3_ff;
   logic        v3_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rad1_ff <= 62'(sq1_ff[0]) + 62'(sq1_ff[1]) + 62'(sq1_ff[2]) + 62'(msq1_ff);
         rad2_ff <= 62'(sq2_ff[0]) + 62'(sq2_ff[1]) + 62'(sq2_ff[2]) + 62'(msq2_ff);
         pt3_ff  <= sqs_ff[0] + sqs_ff[1] + sqs_ff[2];
         hyp3_ff <= hyp2_ff;
      end
   end

   // ---- energies
   logic [Rw-1:0] e1, e2;

   vhim_isqrt #(.ROOT_WIDTH(Rw)) u_energy_first (
      .clock    (clock),
      .enable   (advance),
      .radicand (rad1_ff),
      .root     (e1)
   );

   vhim_isqrt #(.ROOT_WIDTH(Rw)) u_energy_second (
      .clock    (clock),
      .enable   (advance),
      .radicand (rad2_ff),
      .root     (e2)
   );

   logic [Rw-1:0] v4_ff;
   logic [61:0]   pt4_ff  [Rw];
   logic [2:0]    hyp4_ff [Rw];

   always_ff @(posedge clock) begin
      if (advance) begin
         pt4_ff[0]  <= pt3_ff;
         hyp4_ff[0] <= hyp3_ff;
         for (int k = 1; k < Rw; k++) begin
            pt4_ff[k]  <= pt4_ff[k-1];
            hyp4_ff[k] <= hyp4_ff[k-1];
         end
      end
   end

   // ---- total energy, its square, mass squared
   logic [31:0] et_ff;
   logic [63:0] etsq_ff;
   logic [61:0] pt5_ff, pt6_ff, diff_ff;
   logic [2:0]  hyp5_ff, hyp6_ff, hyp7_ff;
   logic        v5_ff, v6_ff, v7_ff, pos7_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         et_ff   <= 32'(e1) + 32'(e2);
         pt5_ff  <= pt4_ff[Rw-1];
         hyp5_ff <= hyp4_ff[Rw-1];
         etsq_ff <= et_ff * et_ff;
         pt6_ff  <= pt5_ff;
         hyp6_ff <= hyp5_ff;
         pos7_ff <= etsq_ff > 64'(pt6_ff);
         diff_ff <= 62'(etsq_ff - 64'(pt6_ff));
         hyp7_ff <= hyp6_ff;
      end
   end

   // ---- mass
   logic [Rw-1:0] mass;

   vhim_isqrt #(.ROOT_WIDTH(Rw)) u_mass (
      .clock    (clock),
      .enable   (advance),
      .radicand (diff_ff),
      .root     (mass)
   );

   logic [Rw-1:0] v8_ff, pos8_ff;
   logic [2:0]    hyp8_ff [Rw];

   always_ff @(posedge clock) begin
      if (advance) begin
         pos8_ff    <= {pos8_ff[Rw-2:0], pos7_ff};
         hyp8_ff[0] <= hyp7_ff;
         for (int k = 1; k < Rw; k++) begin
            hyp8_ff[k] <= hyp8_ff[k-1];
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= '0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= '0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= {v4_ff[Rw-2:0], v3_ff};
         v5_ff <= v4_ff[Rw-1];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= {v8_ff[Rw-2:0], v7_ff};
      end
   end

   // ---- output register
   logic        rsp_valid_ff;
   logic [30:0] rsp_mass_ff;
   logic [2:0]  rsp_hyp_ff;
   logic [1:0]  rsp_status_ff;
   logic [2:0]  hyp_out;
   logic        pos_out;

   assign hyp_out = hyp8_ff[Rw-1];
   assign pos_out = pos8_ff[Rw-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v8_ff[Rw-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hyp_ff <= hyp_out;
         if (hyp_out == HYP_NONE) begin
            rsp_mass_ff   <= '0;
            rsp_status_ff <= STATUS_NO_MATCH;
         end else if (!pos_out) begin
            rsp_mass_ff   <= '0;
            rsp_status_ff <= STATUS_FAILURE;
         end else begin
            rsp_mass_ff   <= 31'(mass);
            rsp_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_invariant_mass = rsp_mass_ff;
   assign rsp_hypothesis     = rsp_hyp_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

### tb/sv/v0_hypothesis_invariant_mass_test.sv
// Scoreboard-based stimulus and checking for the V0 hypothesis invariant mass block.
module v0_hypothesis_invariant_mass_test
   import vhim_pkg::*;
();

   typedef struct packed {
      logic signed [29:0] p1x, p1y, p1z, p2x, p2y, p2z;
      logic signed [24:0] c1, c2;
   } track_pair_type;

   typedef struct packed {
      logic [30:0] mass;
      logic [2:0]  hyp;
      logic [1:0]  status;
   } mass_result_type;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   class mass_scoreboard;
      mass_result_type expected_q[$];
      int unsigned  errors;
      logic [19:0]  electron_mass, pion_mass, proton_mass;

      function new();
         errors        = 0;
         electron_mass = ELECTRON_MASS_RESET;
         pion_mass     = PION_MASS_RESET;
         proton_mass   = PROTON_MASS_RESET;
      endfunction

      function void write_mass(logic [1:0] idx, logic [19:0] val);
         if (idx == REG_ELECTRON_MASS) electron_mass = val;
         else if (idx == REG_PION_MASS) pion_mass = val;
         else if (idx == REG_PROTON_MASS) proton_mass = val;
      endfunction

      function longint unsigned root64(longint unsigned v);
         longint unsigned r, bit_pos;
         r = 0;
         bit_pos = 64'd1 << 62;
         while (bit_pos > v) bit_pos = bit_pos >> 2;
         while (bit_pos != 0) begin
            if (v >= r + bit_pos) begin
               v = v - (r + bit_pos);
               r = (r >> 1) + bit_pos;
            end else begin
               r = r >> 1;
            end
            bit_pos = bit_pos >> 2;
         end
         return r;
      endfunction

      function longint unsigned sq(longint signed v);
         longint unsigned a;
         a = (v < 0) ? -v : v;
         return a * a;
      endfunction

      function longint signed clamp(longint signed v);
         longint signed lim;
         lim = (longint'(1) <<< (MOMENTUM_WIDTH_DEFAULT - 1)) - 1;
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function mass_result_type predict_mass(track_pair_type t);
         mass_result_type r;
         int              a1, a2, c1, c2;
         longint unsigned m1, m2, e1, e2, et, s1, s2, st;
         longint signed   ax, ay, az, bx, by, bz;
         c1 = t.c1;
         c2 = t.c2;
         a1 = (c1 < 0) ? -c1 : c1;
         a2 = (c2 < 0) ? -c2 : c2;
         r = '0;
         m1 = 0;
         m2 = 0;
         if (a1 == E_MINUS && a2 == E_MINUS) begin
            m1 = electron_mass; m2 = electron_mass; r.hyp = PHOTON;
         end else if (a1 == PI_PLUS && a2 == PI_PLUS) begin
            m1 = pion_mass; m2 = pion_mass; r.hyp = K_SHORT;
         end else if (a1 == PROTON && a2 == PI_PLUS) begin
            m1 = proton_mass; m2 = pion_mass;
            r.hyp = (c1 == PROTON) ? LAMBDA : ANTI_LAMBDA;
         end else if (a1 == PI_PLUS && a2 == PROTON) begin
            m1 = pion_mass; m2 = proton_mass;
            r.hyp = (c2 == PROTON) ? LAMBDA : ANTI_LAMBDA;
         end
         if (r.hyp == HYP_NONE) begin
            r.status = STATUS_NO_MATCH;
            return r;
         end
         ax = clamp(t.p1x); ay = clamp(t.p1y); az = clamp(t.p1z);
         bx = clamp(t.p2x); by = clamp(t.p2y); bz = clamp(t.p2z);
         s1 = sq(ax) + sq(ay) + sq(az);
         s2 = sq(bx) + sq(by) + sq(bz);
         st = sq(ax + bx) + sq(ay + by) + sq(az + bz);
         e1 = root64(s1 + m1 * m1);
         e2 = root64(s2 + m2 * m2);
         et = (e1 + e2) * (e1 + e2);
         if (et <= st) begin
            r.status = STATUS_FAILURE;
         end else begin
            r.mass   = 31'(root64(et - st));
            r.status = STATUS_OK;
         end
         return r;
      endfunction

      function void note_pair(track_pair_type t);
         expected_q.push_back(predict_mass(t));
      endfunction

      function void check_result(mass_result_type got);
         mass_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result mass=%0d hyp=%0d status=%0d",
                     $time, got.mass, got.hyp, got.status);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.mass !== exp_r.mass) begin
            $display("%0t: invariant_mass expected %0d actual %0d",
                     $time, exp_r.mass, got.mass);
            errors++;
         end
         if (got.hyp !== exp_r.hyp) begin
            $display("%0t: hypothesis expected %0d actual %0d",
                     $time, exp_r.hyp, got.hyp);
            errors++;
         end
         if (got.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_r.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [29:0] req_first_px = '0, req_first_py = '0, req_first_pz = '0;
   logic signed [29:0] req_second_px = '0, req_second_py = '0, req_second_pz = '0;
   logic signed [24:0] req_first_code = '0, req_second_code = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [30:0]        rsp_invariant_mass;
   logic [2:0]         rsp_hypothesis;
   logic [1:0]         rsp_status;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [19:0]        csr_write_data = '0;

   mass_scoreboard sb = new();
   int unsigned    cycles = 0;
   int unsigned    burst_left = 0;
   int unsigned    stall_mode = 0, stall_left = 0;

   v0_hypothesis_invariant_mass uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_invariant_mass, rsp_hypothesis, rsp_status});
   end

   // receiver: ready pattern switches between open, choppy and long stalls
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         default: rsp_ready = ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic write_csr(logic [1:0] idx, logic [19:0] val);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_mass(idx, val);
   endtask

   task automatic drain();
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic send_pair(track_pair_type t);
      req_valid       = 1'b1;
      req_first_px    = t.p1x;
      req_first_py    = t.p1y;
      req_first_pz    = t.p1z;
      req_second_px   = t.p2x;
      req_second_py   = t.p2y;
      req_second_pz   = t.p2z;
      req_first_code  = t.c1;
      req_second_code = t.c2;
      do @(posedge clock); while (!req_ready);
      sb.note_pair(t);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic signed [29:0] rand_momentum();
      case ($urandom_range(0, 4))
         0, 1: return 30'($urandom);
         2: return $signed(30'($urandom_range(0, 4000000))) - 30'sd2000000;
         3: return $signed(30'($urandom_range(0, 1 << 21))) - 30'sd1048576;
         default: begin
            case ($urandom_range(0, 3))
               0: return -30'sd536870912;
               1: return 30'sd536870911;
               2: return '0;
               default: return -30'sd536870911;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [24:0] rand_code();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0, 1, 2: return 25'(E_MINUS);
         3, 4: return 25'(-E_MINUS);
         5, 6, 7: return 25'(PI_PLUS);
         8, 9, 10: return 25'(NEG_PION);
         11, 12, 13: return 25'(PROTON);
         14, 15: return 25'(-PROTON);
         16: return 25'sd13;
         17: return 25'sd2211;
         default: return 25'($urandom);
      endcase
   endfunction

   task automatic random_pairs(int n);
      track_pair_type t;
      repeat (n) begin
         t.p1x = rand_momentum(); t.p1y = rand_momentum(); t.p1z = rand_momentum();
         t.p2x = rand_momentum(); t.p2y = rand_momentum(); t.p2z = rand_momentum();
         t.c1 = rand_code();
         t.c2 = rand_code();
         // back-to-back tracks: the second track mirrors the momentum of the first
         if ($urandom_range(0, 9) == 0) begin
            t.p2x = -t.p1x; t.p2y = -t.p1y; t.p2z = -t.p1z;
         end
         send_pair(t);
      end
   endtask

   task automatic directed_pairs();
      track_pair_type t;
      t = '0;
      t.c1 = 25'(E_MINUS);  t.c2 = 25'(E_MINUS);  send_pair(t);
      t.c1 = 25'(-E_MINUS); t.c2 = 25'(E_MINUS);  t.p1x = 30'sd1000; t.p2y = 30'sd2000;
      send_pair(t);
      t.c1 = 25'(PI_PLUS);  t.c2 = 25'(NEG_PION);
      t.p1z = 30'sd400000; t.p2z = -30'sd300000;
      send_pair(t);
      t.c1 = 25'(PROTON);   t.c2 = 25'(NEG_PION); send_pair(t);
      t.c1 = 25'(-PROTON);  t.c2 = 25'(PI_PLUS);  send_pair(t);
      t.c1 = 25'(PI_PLUS);  t.c2 = 25'(PROTON);   send_pair(t);
      t.c1 = 25'(NEG_PION); t.c2 = 25'(-PROTON);  send_pair(t);
      t.c1 = 25'(E_MINUS);  t.c2 = 25'(PI_PLUS);  send_pair(t);
      t.c1 = 25'(PROTON);   t.c2 = 25'(PROTON);   send_pair(t);
      t.c1 = 25'sh0FFFFFF; t.c2 = -25'sh1000000; send_pair(t);
      t.c1 = 25'sd9999999; t.c2 = -25'sd9999999; send_pair(t);
      t.c1 = '0; t.c2 = '0; send_pair(t);
      t.c1 = 25'(PI_PLUS); t.c2 = 25'(PI_PLUS);
      t.p1x = 30'sd536870911; t.p1y = 30'sd536870911; t.p1z = 30'sd536870911;
      t.p2x = 30'sd536870911; t.p2y = 30'sd536870911; t.p2z = 30'sd536870911;
      send_pair(t);
      t.p1x = -30'sd536870912; t.p1y = -30'sd536870912; t.p1z = -30'sd536870912;
      t.p2x = -30'sd536870912; t.p2y = -30'sd536870912; t.p2z = -30'sd536870912;
      send_pair(t);
      t.p2x = 30'sd536870911; t.p2y = 30'sd536870911; t.p2z = 30'sd536870911;
      send_pair(t);
      t.c1 = 25'(PROTON); t.c2 = 25'(NEG_PION);
      t.p1x = 30'sd123456; t.p1y = -30'sd654321; t.p1z = 30'sd1;
      t.p2x = -30'sd123456; t.p2y = 30'sd654321; t.p2z = -30'sd1;
      send_pair(t);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      directed_pairs();
      random_pairs(120);

      // mass registers at their lower extreme: zero-mass tracks
      req_valid = 1'b0;
      drain();
      write_csr(REG_ELECTRON_MASS, '0);
      write_csr(REG_PION_MASS, '0);
      write_csr(REG_PROTON_MASS, '0);
      directed_pairs();
      random_pairs(120);

      req_valid = 1'b0;
      drain();
      write_csr(REG_ELECTRON_MASS, 20'hFFFFF);
      write_csr(REG_PION_MASS, 20'hFFFFF);
      write_csr(REG_PROTON_MASS, 20'hFFFFF);
      write_csr(REG_UNMAPPED, 20'h5A5A5); // unmapped index, must be ignored
      random_pairs(130);

      req_valid = 1'b0;
      drain();
      write_csr(REG_ELECTRON_MASS, 20'($urandom));
      write_csr(REG_PION_MASS, 20'($urandom));
      write_csr(REG_PROTON_MASS, 20'($urandom));
      random_pairs(130);

      req_valid = 1'b0;
      drain();
      write_csr(REG_ELECTRON_MASS, ELECTRON_MASS_RESET);
      write_csr(REG_PION_MASS, PION_MASS_RESET);
      write_csr(REG_PROTON_MASS, PROTON_MASS_RESET);
      random_pairs(130);

      req_valid = 1'b0;
      drain();
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
